### rtl/mfqs_pkg.sv
package mfqs_pkg;

    // level and slice geometry
    localparam int LEVELS    = 3;
    localparam int LEVEL_W   = 2;
    localparam int SLICE_W   = 3;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [SLICE_W-1:0] slice_t;

    localparam level_t LEVEL_TOP    = 2'd0;
    localparam level_t LOWEST_LEVEL = 2'd2;
    localparam slice_t SLICE_MAX    = 3'd7;

    // opcodes of an input item
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TOP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW = 2'd2;

    // reset values of the slice limits
    localparam slice_t LIMIT_TOP_RST = 3'd1;
    localparam slice_t LIMIT_MID_RST = 3'd2;
    localparam slice_t LIMIT_LOW_RST = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_NOSEL = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FIELD_W-1:0] task_id;
        logic               ran_quantum;
        logic               still_alive;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] chosen_id;
        logic [1:0]         chosen_level;
    } result_t;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_SELECT,
        CMD_REPORT,
        CMD_NOP
    } cmd_kind_t;

    // classified item handed from front to back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [FIELD_W-1:0] task_id;
        logic               ran;
        logic               alive;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

endpackage

### rtl/multilevel_feedback_queue_scheduler_unit.sv
// Three-level feedback queue scheduler for task ids. Items enter through a
// two-entry queue (push/full) and results leave through a one-entry result
// register (empty/pop); every item gives exactly one result. In the back
// end an add, an unknown opcode, a select with nothing queued and a report
// that does not move a task finish in the idle state; a select and a report
// that demotes or rotates a task also pass through the read state, for the
// registered read of the id store (a single RAM of 3 x QUEUE_DEPTH entries,
// one region per level) ahead of the result or the write-back. The id store
// has no reset and needs no clearing pass: only heads of non-empty levels
// are read. The slice limit registers (cfg_write/cfg_index/cfg_data) are
// to be written by the user only while the block is idle, which the block
// itself does not enforce; indexes beyond the three limits are ignored.
module multilevel_feedback_queue_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      push,
    input  mfqs_pkg::request_t                        request,
    output logic                                      full,
    output logic                                      empty,
    input  logic                                      pop,
    output mfqs_pkg::result_t                         result,
    input  logic                                      cfg_write,
    input  logic [mfqs_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [mfqs_pkg::SLICE_W-1:0]              cfg_data
);
    import mfqs_pkg::*;

    slice_t [LEVELS-1:0] limit_reg;
    slice_t [LEVELS-1:0] limit_next;
    logic                cmd_valid;
    logic                cmd_ready;
    cmd_t                cmd;

    // slice limit registers
    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LIMIT_TOP: limit_next[0] = cfg_data;
                REG_LIMIT_MID: limit_next[1] = cfg_data;
                REG_LIMIT_LOW: limit_next[2] = cfg_data;
                default:       limit_next    = limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg[0] <= LIMIT_TOP_RST;
            limit_reg[1] <= LIMIT_MID_RST;
            limit_reg[2] <= LIMIT_LOW_RST;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    mfqs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .request   (request),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    mfqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .limits    (limit_reg),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### rtl/mfqs_ram.sv
module mfqs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mfqs_front.sv
module mfqs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfqs_pkg::request_t request,
    output logic              full,
    output logic              cmd_valid,
    output mfqs_pkg::cmd_t    cmd,
    input  logic              cmd_ready
);
    import mfqs_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       decoded;
    logic       do_push;
    logic       do_pop;

    // classify the incoming item
    always_comb
    begin
        decoded.task_id = request.task_id;
        decoded.ran     = request.ran_quantum;
        decoded.alive   = request.still_alive;
        unique case (request.opcode)
            OP_ADD:    decoded.kind = CMD_ADD;
            OP_SELECT: decoded.kind = CMD_SELECT;
            OP_REPORT: decoded.kind = CMD_REPORT;
            default:   decoded.kind = CMD_NOP;
        endcase
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_valid && cmd_ready;

    // two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

### rtl/mfqs_back.sv
module mfqs_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_valid,
    input  mfqs_pkg::cmd_t                          cmd,
    output logic                                    cmd_ready,
    input  mfqs_pkg::slice_t [mfqs_pkg::LEVELS-1:0] limits,
    output mfqs_pkg::result_t                       result,
    output logic                                    empty,
    input  logic                                    pop
);
    import mfqs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE  = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE);

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] head_reg [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] count_reg [LEVELS];
    logic [CNT_W-1:0] count_next [LEVELS];
    slice_t           slice_reg [LEVELS];
    slice_t           slice_next [LEVELS];
    logic [CNT_W-1:0] total_reg, total_next;
    level_t           sel_level_reg, sel_level_next;
    logic             sel_valid_reg, sel_valid_next;
    logic             pend_select_reg, pend_select_next;
    level_t           pend_level_reg, pend_level_next;
    level_t           pend_dest_reg, pend_dest_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic              start;
    logic              need_read;
    logic              any_task;
    level_t            first_lv;
    logic              report_ok;
    slice_t            slice_inc;
    logic              at_limit;
    level_t            demote_lv;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ID_WIDTH-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_WIDTH-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] store_addr(level_t lv, logic [PTR_W-1:0] p);
        return ADDR_W'(lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] wrap_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // highest non-empty level
    always_comb
    begin
        any_task = 1'b1;
        first_lv = LEVEL_TOP;
        if (count_reg[0] != '0)
        begin
            first_lv = 2'd0;
        end
        else if (count_reg[1] != '0)
        begin
            first_lv = 2'd1;
        end
        else if (count_reg[2] != '0)
        begin
            first_lv = 2'd2;
        end
        else
        begin
            any_task = 1'b0;
        end
    end

    // report outcome of the selected level
    assign report_ok = sel_valid_reg && (count_reg[sel_level_reg] != '0);
    assign slice_inc = (cmd.ran && slice_reg[sel_level_reg] < SLICE_MAX)
                     ? slice_reg[sel_level_reg] + 3'd1 : slice_reg[sel_level_reg];
    assign at_limit  = (slice_inc >= limits[sel_level_reg]);
    assign demote_lv = (sel_level_reg < LOWEST_LEVEL) ? sel_level_reg + 2'd1 : sel_level_reg;

    // start an item only when the result slot is free or being emptied
    assign start     = (state_reg == BK_IDLE) && cmd_valid && (!out_valid_reg || pop);
    assign cmd_ready = start;
    assign need_read = ((cmd.kind == CMD_SELECT) && any_task)
                    || ((cmd.kind == CMD_REPORT) && report_ok && cmd.alive && at_limit);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start && need_read)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and store access
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        slice_next       = slice_reg;
        total_next       = total_reg;
        sel_level_next   = sel_level_reg;
        sel_valid_next   = sel_valid_reg;
        pend_select_next = pend_select_reg;
        pend_level_next  = pend_level_reg;
        pend_dest_next   = pend_dest_reg;
        out_valid_next   = out_valid_reg && !pop;
        res_next         = res_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    res_next = '{status: STAT_OK, chosen_id: '0, chosen_level: '0};
                    out_valid_next = !need_read;
                    case (cmd.kind)
                        CMD_ADD:
                        begin
                            if (total_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                ram_we        = 1'b1;
                                ram_waddr     = store_addr(LEVEL_TOP, tail_reg[0]);
                                ram_wdata     = ID_WIDTH'(cmd.task_id);
                                tail_next[0]  = wrap_next(tail_reg[0]);
                                count_next[0] = count_reg[0] + CNT_W'(1);
                                total_next    = total_reg + CNT_W'(1);
                            end
                        end
                        CMD_SELECT:
                        begin
                            sel_valid_next = 1'b0;
                            if (any_task)
                            begin
                                ram_re           = 1'b1;
                                ram_raddr        = store_addr(first_lv, head_reg[first_lv]);
                                pend_select_next = 1'b1;
                                pend_level_next  = first_lv;
                                sel_level_next   = first_lv;
                                sel_valid_next   = 1'b1;
                            end
                            else
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                        end
                        CMD_REPORT:
                        begin
                            if (!report_ok)
                            begin
                                res_next.status = STAT_NOSEL;
                            end
                            else
                            begin
                                sel_valid_next = 1'b0;
                                if (!cmd.alive)
                                begin
                                    // finished task leaves its level
                                    slice_next[sel_level_reg] = '0;
                                    head_next[sel_level_reg]  = wrap_next(head_reg[sel_level_reg]);
                                    count_next[sel_level_reg] =
                                        count_reg[sel_level_reg] - CNT_W'(1);
                                    total_next = total_reg - CNT_W'(1);
                                end
                                else if (at_limit)
                                begin
                                    // fetch head, moved in the next cycle
                                    slice_next[sel_level_reg] = '0;
                                    ram_re           = 1'b1;
                                    ram_raddr        = store_addr(sel_level_reg,
                                                                  head_reg[sel_level_reg]);
                                    pend_select_next = 1'b0;
                                    pend_level_next  = sel_level_reg;
                                    pend_dest_next   = demote_lv;
                                end
                                else
                                begin
                                    slice_next[sel_level_reg] = slice_inc;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                out_valid_next = 1'b1;
                res_next = '{status: STAT_OK, chosen_id: '0, chosen_level: '0};
                if (pend_select_reg)
                begin
                    res_next.chosen_id    = FIELD_W'(ram_rdata);
                    res_next.chosen_level = pend_level_reg;
                end
                else
                begin
                    // pop head and push it to the tail of the destination level
                    head_next[pend_level_reg]  = wrap_next(head_reg[pend_level_reg]);
                    count_next[pend_level_reg] = count_reg[pend_level_reg] - CNT_W'(1);
                    ram_we    = 1'b1;
                    ram_waddr = store_addr(pend_dest_reg, tail_reg[pend_dest_reg]);
                    ram_wdata = ram_rdata;
                    tail_next[pend_dest_reg]  = wrap_next(tail_reg[pend_dest_reg]);
                    count_next[pend_dest_reg] = count_next[pend_dest_reg] + CNT_W'(1);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            head_reg        <= '{default: '0};
            tail_reg        <= '{default: '0};
            count_reg       <= '{default: '0};
            slice_reg       <= '{default: '0};
            total_reg       <= '0;
            sel_level_reg   <= LEVEL_TOP;
            sel_valid_reg   <= 1'b0;
            pend_select_reg <= 1'b0;
            pend_level_reg  <= LEVEL_TOP;
            pend_dest_reg   <= LEVEL_TOP;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            slice_reg       <= slice_next;
            total_reg       <= total_next;
            sel_level_reg   <= sel_level_next;
            sel_valid_reg   <= sel_valid_next;
            pend_select_reg <= pend_select_next;
            pend_level_reg  <= pend_level_next;
            pend_dest_reg   <= pend_dest_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result = res_reg;
    assign empty  = !out_valid_reg;

    // id store, one region of QUEUE_DEPTH entries per level
    mfqs_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (STORE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == CNT_W'(count_reg[0] + count_reg[1] + count_reg[2]))
        else $error("task total differs from sum of level counts");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("task total above queue depth");
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |-> !out_valid_reg)
        else $error("result slot busy during store read");
    a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |=> state_reg == BK_IDLE && out_valid_reg)
        else $error("store read did not complete an item");
    a_no_start_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> state_reg == BK_IDLE)
        else $error("item taken while store read pending");
`endif

endmodule
